/* design/acc_pkg.sv */
// shared types and constants for the actuator command conditioner
package acc_pkg;

  // request codes on the command field
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // configuration register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_FORCE_LIMIT   = 3'd0,
    REG_SLEW_STEP     = 3'd1,
    REG_DEADBAND      = 3'd2,
    REG_LATENCY       = 3'd3,
    REG_DROPOUT_THR   = 3'd4
  } reg_idx_e;

  localparam int ForceW  = 24;
  localparam int LimitW  = 23;
  localparam int OriginW = 2;
  localparam int StampW  = 32;
  localparam int LatW    = 4;
  localparam int ThrW    = 32;
  localparam int AddrW   = 5;

  // one delay ring entry
  typedef struct packed {
    logic [OriginW-1:0]       origin;
    logic signed [ForceW-1:0] value;
  } ring_entry_t;

  // register reset values
  localparam logic [LimitW-1:0] ForceLimitRst = 23'd1310720;
  localparam logic [LimitW-1:0] SlewStepRst   = 23'd58982;
  localparam logic [LimitW-1:0] DeadbandRst   = 23'd3277;
  localparam logic [LatW-1:0]   LatencyRst    = 4'd2;
  localparam logic [ThrW-1:0]   DropoutThrRst = 32'd2147484;

  // pcg32 lcg constants
  localparam logic [63:0] PcgMult = 64'd6364136223846793005;
  localparam logic [63:0] PcgInc  = 64'd1442695040888963407;
  localparam logic [63:0] RngSeed = 64'h0000_0000_0caa_7701;
  localparam int          XsShift = 27;
  localparam int          RotPos  = 59;

  // two-step leap: s(n+2) = PcgMult2 * s(n) + PcgInc2
  localparam logic [63:0] PcgMult2 = PcgMult * PcgMult;
  localparam logic [63:0] PcgInc2  = PcgMult * PcgInc + PcgInc;
  // state after one step from the seed
  localparam logic [63:0] RngSeed1 = PcgMult * RngSeed + PcgInc;
  // partial-product reset so the leap adder yields the second state
  localparam logic [63:0] LeapPartRst = RngSeed1 - PcgInc2;

endpackage

/* design/actuator_command_conditioner_core.sv */
// actuator command conditioner: delay ring, deadband, clamp, slew limit, dropout draw
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------------
//   in       | in_valid_i / in_ready_o    | command, command_force, command_origin,
//            |                            | time_stamp
//   out      | out_valid_o / out_ready_i  | out_stamp, requested_force, applied_force,
//            |                            | clamp_hit, slew_hit, deadband_hit,
//            |                            | acted_origin, dropout_flag
//   config   | apb psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// one request per cycle sustained unless the output stalls; a push finishes at its
// accept edge, a tick reaches out_valid_o through registered steps (ring read and draw
// at the accept edge, then deadband/clamp stage, then slew stage into the output register)
// the ring is a synchronous memory with a registered read, read at the tick accept
// the pcg state steps through a two-deep leapfrog loop, one state per accepted tick
// reset is asynchronous and needs no clearing pass; ring entries are only used once written
// a stalled output fills the tick pipeline and then drops in_ready_o
module actuator_command_conditioner_core #(
  parameter int DELAY_DEPTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  command_i,
  input  logic signed [acc_pkg::ForceW-1:0]     command_force_i,
  input  logic [acc_pkg::OriginW-1:0]           command_origin_i,
  input  logic [acc_pkg::StampW-1:0]            time_stamp_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [acc_pkg::StampW-1:0]            out_stamp_o,
  output logic signed [acc_pkg::ForceW-1:0]     requested_force_o,
  output logic signed [acc_pkg::ForceW-1:0]     applied_force_o,
  output logic                                  clamp_hit_o,
  output logic                                  slew_hit_o,
  output logic                                  deadband_hit_o,
  output logic [acc_pkg::OriginW-1:0]           acted_origin_o,
  output logic                                  dropout_flag_o,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [acc_pkg::AddrW-1:0]             paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int FW = $clog2(DELAY_DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int CW = (FW > acc_pkg::LatW) ? FW : acc_pkg::LatW;
  localparam int FRW = acc_pkg::ForceW;
  localparam int LMW = acc_pkg::LimitW;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [LMW-1:0]               max_force_q;
  logic [LMW-1:0]               slew_step_q;
  logic [LMW-1:0]               deadband_q;
  logic [acc_pkg::LatW-1:0]     latency_q;
  logic [acc_pkg::ThrW-1:0]     dropout_thr_q;
  logic                         cfg_wr;
  acc_pkg::reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = acc_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_force_q   <= acc_pkg::ForceLimitRst;
      slew_step_q   <= acc_pkg::SlewStepRst;
      deadband_q    <= acc_pkg::DeadbandRst;
      latency_q     <= acc_pkg::LatencyRst;
      dropout_thr_q <= acc_pkg::DropoutThrRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        acc_pkg::REG_FORCE_LIMIT: max_force_q   <= pwdata[LMW-1:0];
        acc_pkg::REG_SLEW_STEP:   slew_step_q   <= pwdata[LMW-1:0];
        acc_pkg::REG_DEADBAND:    deadband_q    <= pwdata[LMW-1:0];
        acc_pkg::REG_LATENCY:     latency_q     <= pwdata[acc_pkg::LatW-1:0];
        acc_pkg::REG_DROPOUT_THR: dropout_thr_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      acc_pkg::REG_FORCE_LIMIT: prdata = 32'(max_force_q);
      acc_pkg::REG_SLEW_STEP:   prdata = 32'(slew_step_q);
      acc_pkg::REG_DEADBAND:    prdata = 32'(deadband_q);
      acc_pkg::REG_LATENCY:     prdata = 32'(latency_q);
      acc_pkg::REG_DROPOUT_THR: prdata = dropout_thr_q;
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: accept stage, conditioning stage, slew stage, output
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic o_free, s2_free, s1_free;
  logic in_acc, push_acc, tick_acc;

  assign o_free   = ~out_valid_q | out_ready_i;
  assign s2_free  = ~s2_valid_q | o_free;
  assign s1_free  = ~s1_valid_q | s2_free;
  assign in_ready_o = s1_free;
  assign in_acc   = in_valid_i & in_ready_o;
  assign push_acc = in_acc & (command_i == acc_pkg::CMD_PUSH);
  assign tick_acc = in_acc & (command_i == acc_pkg::CMD_TICK);

  // ---------------------------------------------------------------------------
  // delay ring: memory plus head/fill pointers and the latest command
  // ---------------------------------------------------------------------------
  acc_pkg::ring_entry_t ring_mem [DELAY_DEPTH];
  acc_pkg::ring_entry_t ring_rdata_q;
  acc_pkg::ring_entry_t latest_q;
  acc_pkg::ring_entry_t push_entry;
  logic [AW-1:0]        head_q, head_d, head_inc;
  logic [FW-1:0]        fill_q, fill_d;
  logic                 ring_full;
  logic                 pop;
  logic [SW-1:0]        tail_sum, tail_wrap;
  logic [AW-1:0]        ring_waddr;

  assign push_entry.origin = command_origin_i;
  assign push_entry.value  = command_force_i;

  assign ring_full = (fill_q == FW'(DELAY_DEPTH));
  assign head_inc  = (head_q == AW'(DELAY_DEPTH - 1)) ? '0 : head_q + 1'b1;
  // tail slot, head + fill wrapped once around the ring
  assign tail_sum  = SW'(head_q) + SW'(fill_q);
  assign tail_wrap = (tail_sum >= SW'(DELAY_DEPTH)) ? tail_sum - SW'(DELAY_DEPTH) : tail_sum;
  assign ring_waddr = ring_full ? head_q : tail_wrap[AW-1:0];
  // pop when fill exceeds latency setting
  assign pop = (CW'(fill_q) > CW'(latency_q)) && (fill_q != '0);

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (push_acc) begin
      if (ring_full) begin
        head_d = head_inc;               // oldest entry dropped
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end else if (tick_acc && pop) begin
      head_d = head_inc;
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      fill_q   <= '0;
      latest_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      if (push_acc) begin
        latest_q <= push_entry;
      end
    end
  end

  // ring memory write and registered read
  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      ring_mem[ring_waddr] <= push_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      ring_rdata_q <= ring_mem[head_q];
    end
  end

  // ---------------------------------------------------------------------------
  // pcg32 generator: state steps once per tick through a two-deep leapfrog loop
  // rng_q holds the current state; the partial products hold the previous state's
  // products with the two-step multiplier, so the adder yields the next state
  // ---------------------------------------------------------------------------
  logic [63:0] rng_q;
  logic [63:0] leap_p0_q;
  logic [31:0] leap_p1_q, leap_p2_q;
  logic [63:0] leap_sum;
  logic [31:0] cross_sum;
  logic [63:0] mix_word;
  logic [31:0] xs_word;
  logic [4:0]  rot_amt;
  logic [63:0] rot_word;
  logic [31:0] draw_word;
  logic        drop_now;

  assign cross_sum = leap_p1_q + leap_p2_q;
  assign leap_sum  = leap_p0_q + {cross_sum, 32'd0} + acc_pkg::PcgInc2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q     <= acc_pkg::RngSeed;
      leap_p0_q <= acc_pkg::LeapPartRst;
      leap_p1_q <= '0;
      leap_p2_q <= '0;
    end else if (tick_acc) begin
      rng_q     <= leap_sum;
      leap_p0_q <= rng_q[31:0] * acc_pkg::PcgMult2[31:0];
      leap_p1_q <= 32'(rng_q[63:32] * acc_pkg::PcgMult2[31:0]);
      leap_p2_q <= 32'(rng_q[31:0] * acc_pkg::PcgMult2[63:32]);
    end
  end

  // xorshift-high then rotate right by the top five bits
  assign mix_word  = (rng_q >> 18) ^ rng_q;
  assign xs_word   = mix_word[acc_pkg::XsShift +: 32];
  assign rot_amt   = rng_q[acc_pkg::RotPos +: 5];
  assign rot_word  = {xs_word, xs_word} >> rot_amt;
  assign draw_word = rot_word[31:0];
  assign drop_now  = (draw_word < dropout_thr_q);

  // ---------------------------------------------------------------------------
  // stage 1: command select, deadband and clamp
  // ---------------------------------------------------------------------------
  logic                       s1_pop_q;
  acc_pkg::ring_entry_t       s1_latest_q;
  logic [acc_pkg::StampW-1:0] s1_stamp_q;
  logic                       s1_drop_q;

  acc_pkg::ring_entry_t       s1_entry;
  logic signed [FRW-1:0]      s1_req;
  logic [FRW-1:0]             s1_mag;
  logic                       s1_neg, s1_in_db, s1_db_hit, s1_over;
  logic signed [FRW-1:0]      s1_db_val;
  logic [FRW-1:0]             s1_db_mag;
  logic signed [FRW-1:0]      s1_lim_pos, s1_lim_neg;
  logic signed [FRW-1:0]      s1_clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= tick_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_pop_q    <= pop;
      s1_latest_q <= latest_q;
      s1_stamp_q  <= time_stamp_i;
      s1_drop_q   <= drop_now;
    end
  end

  assign s1_entry = s1_pop_q ? ring_rdata_q : s1_latest_q;
  assign s1_req   = s1_entry.value;
  assign s1_neg   = s1_req[FRW-1];
  // magnitude as unsigned, exact for the most negative force too
  assign s1_mag   = s1_neg ? FRW'(-s1_req) : FRW'(s1_req);
  assign s1_in_db = (s1_mag < {1'b0, deadband_q});
  assign s1_db_hit = s1_in_db & (s1_req != '0);
  assign s1_db_val = s1_in_db ? '0 : s1_req;
  assign s1_db_mag = s1_in_db ? '0 : s1_mag;
  assign s1_over   = (s1_db_mag > {1'b0, max_force_q});
  assign s1_lim_pos = {1'b0, max_force_q};
  assign s1_lim_neg = -s1_lim_pos;
  assign s1_clamped = s1_over ? (s1_neg ? s1_lim_neg : s1_lim_pos) : s1_db_val;

  // ---------------------------------------------------------------------------
  // stage 2: slew limit against the last applied force
  // ---------------------------------------------------------------------------
  logic signed [FRW-1:0]       s2_req_q, s2_val_q;
  logic                        s2_db_q, s2_cl_q, s2_drop_q;
  logic [acc_pkg::OriginW-1:0] s2_origin_q;
  logic [acc_pkg::StampW-1:0]  s2_stamp_q;
  logic signed [FRW-1:0]       last_applied_q;
  logic signed [FRW:0]         slew_lo, slew_hi, s2_val_x;
  logic signed [FRW:0]         s2_slewed;
  logic                        s2_sl_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_valid_q) begin
      s2_req_q    <= s1_req;
      s2_val_q    <= s1_clamped;
      s2_db_q     <= s1_db_hit;
      s2_cl_q     <= s1_over;
      s2_origin_q <= s1_entry.origin;
      s2_stamp_q  <= s1_stamp_q;
      s2_drop_q   <= s1_drop_q;
    end
  end

  assign slew_lo  = {last_applied_q[FRW-1], last_applied_q} - {2'b00, slew_step_q};
  assign slew_hi  = {last_applied_q[FRW-1], last_applied_q} + {2'b00, slew_step_q};
  assign s2_val_x = {s2_val_q[FRW-1], s2_val_q};

  always_comb begin
    s2_slewed = s2_val_x;
    s2_sl_hit = 1'b0;
    if (s2_val_x < slew_lo) begin
      s2_slewed = slew_lo;
      s2_sl_hit = 1'b1;
    end else if (s2_val_x > slew_hi) begin
      s2_slewed = slew_hi;
      s2_sl_hit = 1'b1;
    end
  end

  // last applied force moves with each tick leaving the slew stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_applied_q <= '0;
    end else if (s2_valid_q && o_free) begin
      last_applied_q <= s2_slewed[FRW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [acc_pkg::StampW-1:0]  out_stamp_q;
  logic signed [FRW-1:0]       out_req_q, out_applied_q;
  logic                        out_cl_q, out_sl_q, out_db_q, out_drop_q;
  logic [acc_pkg::OriginW-1:0] out_origin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (o_free) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_free && s2_valid_q) begin
      out_stamp_q   <= s2_stamp_q;
      out_req_q     <= s2_req_q;
      out_applied_q <= s2_slewed[FRW-1:0];
      out_cl_q      <= s2_cl_q;
      out_sl_q      <= s2_sl_hit;
      out_db_q      <= s2_db_q;
      out_origin_q  <= s2_origin_q;
      out_drop_q    <= s2_drop_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_stamp_o       = out_stamp_q;
  assign requested_force_o = out_req_q;
  assign applied_force_o   = out_applied_q;
  assign clamp_hit_o       = out_cl_q;
  assign slew_hit_o        = out_sl_q;
  assign deadband_hit_o    = out_db_q;
  assign acted_origin_o    = out_origin_q;
  assign dropout_flag_o    = out_drop_q;

endmodule
